FILE: hdl/csf_pkg.sv
package csf_pkg;

	// queue limit, clamped to what the 8-bit count can hold
	localparam int unsigned QUEUE_MAX   = 255;
	localparam int unsigned QUEUE_LIMIT = (QUEUE_MAX < 255) ? QUEUE_MAX : 255;

	// register byte addresses are 4 * index
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [2:0] {
		REG_DIFS    = 3'd0,
		REG_SEND    = 3'd1,
		REG_SIFS    = 3'd2,
		REG_ACK     = 3'd3,
		REG_WIN_MIN = 3'd4,
		REG_WIN_MAX = 3'd5
	} reg_idx_t;

	// reset values of the registers
	localparam logic [7:0]  DIFS_RST    = 8'd4;
	localparam logic [11:0] SEND_RST    = 12'd100;
	localparam logic [7:0]  SIFS_RST    = 8'd1;
	localparam logic [7:0]  ACK_RST     = 8'd2;
	localparam logic [3:0]  WIN_MIN_RST = 4'd2;
	localparam logic [3:0]  WIN_MAX_RST = 4'd10;

	// largest window exponent the 10-bit random word can serve
	localparam logic [3:0]  WIN_LOG2_CAP = 4'd10;

	// station modes, one-hot
	typedef enum logic [6:0] {
		MODE_WAIT    = 7'b0000001,
		MODE_DIFS    = 7'b0000010,
		MODE_NAV     = 7'b0000100,
		MODE_BACKOFF = 7'b0001000,
		MODE_SENDING = 7'b0010000,
		MODE_SIFS    = 7'b0100000,
		MODE_ACK     = 7'b1000000
	} mode_t;

	// external mode numbering
	localparam logic [2:0] CODE_WAIT    = 3'd0;
	localparam logic [2:0] CODE_DIFS    = 3'd1;
	localparam logic [2:0] CODE_NAV     = 3'd2;
	localparam logic [2:0] CODE_BACKOFF = 3'd3;
	localparam logic [2:0] CODE_SENDING = 3'd4;
	localparam logic [2:0] CODE_SIFS    = 3'd5;
	localparam logic [2:0] CODE_ACK     = 3'd6;

	localparam logic signed [1:0] CHG_NONE    = 2'sd0;
	localparam logic signed [1:0] CHG_OCCUPY  = 2'sd1;
	localparam logic signed [1:0] CHG_RELEASE = -2'sd1;

	typedef struct packed {
		logic [7:0]  difs_slots;
		logic [11:0] send_slots;
		logic [7:0]  sifs_slots;
		logic [7:0]  ack_slots;
		logic [3:0]  window_min_log2;
		logic [3:0]  window_max_log2;
	} cfg_t;

	typedef struct packed {
		logic signed [1:0] channel_change;
		logic [2:0]        station_mode;
		logic              delivered;
		logic              failed;
		logic [7:0]        queue_count;
		logic [15:0]       success_total;
		logic [15:0]       collision_total;
	} res_t;

	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		unique case (m)
			MODE_WAIT:    c = CODE_WAIT;
			MODE_DIFS:    c = CODE_DIFS;
			MODE_NAV:     c = CODE_NAV;
			MODE_BACKOFF: c = CODE_BACKOFF;
			MODE_SENDING: c = CODE_SENDING;
			MODE_SIFS:    c = CODE_SIFS;
			MODE_ACK:     c = CODE_ACK;
			default:      c = CODE_WAIT;
		endcase
		return c;
	endfunction

	// low-bit mask of the contention window, exponent clamped to ten
	function automatic logic [9:0] win_mask(input logic [3:0] lg);
		logic [3:0]  l;
		logic [10:0] m;
		l = (lg > WIN_LOG2_CAP) ? WIN_LOG2_CAP : lg;
		m = (11'd1 << l) - 11'd1;
		return m[9:0];
	endfunction

endpackage

FILE: hdl/csf_regs.sv
module csf_regs
	import csf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.difs_slots      <= DIFS_RST;
			cfg_q.send_slots      <= SEND_RST;
			cfg_q.sifs_slots      <= SIFS_RST;
			cfg_q.ack_slots       <= ACK_RST;
			cfg_q.window_min_log2 <= WIN_MIN_RST;
			cfg_q.window_max_log2 <= WIN_MAX_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_DIFS:    cfg_q.difs_slots      <= pwdata[7:0];
				REG_SEND:    cfg_q.send_slots      <= pwdata[11:0];
				REG_SIFS:    cfg_q.sifs_slots      <= pwdata[7:0];
				REG_ACK:     cfg_q.ack_slots       <= pwdata[7:0];
				REG_WIN_MIN: cfg_q.window_min_log2 <= pwdata[3:0];
				REG_WIN_MAX: cfg_q.window_max_log2 <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_DIFS:    prdata = {24'd0, cfg_q.difs_slots};
			REG_SEND:    prdata = {20'd0, cfg_q.send_slots};
			REG_SIFS:    prdata = {24'd0, cfg_q.sifs_slots};
			REG_ACK:     prdata = {24'd0, cfg_q.ack_slots};
			REG_WIN_MIN: prdata = {28'd0, cfg_q.window_min_log2};
			REG_WIN_MAX: prdata = {28'd0, cfg_q.window_max_log2};
			default:     prdata = '0;
		endcase
	end

endmodule

FILE: hdl/csf_core.sv
module csf_core
	import csf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       packet_arrived,
	input  logic [1:0] channel_level,
	input  logic       ack_valid,
	input  logic [9:0] random_word,
	input  cfg_t       cfg,
	output res_t       res
);

	mode_t       mode_q, mode_n;
	logic [12:0] timer_q, timer_n, t_dec;
	logic [9:0]  backoff_q, backoff_n;
	logic [3:0]  win_q, win_n;
	logic [7:0]  pend_q, pend_n, pend_arr;
	logic        ack_ok_q, ack_ok_n;
	logic [15:0] succ_q, succ_n;
	logic [15:0] coll_q, coll_n;
	logic        busy;
	logic        deliv, fail;
	logic signed [1:0] change;
	logic [12:0] nav_len;

	assign busy    = (channel_level != 2'd0);
	assign nav_len = 13'({1'b0, cfg.send_slots} + {5'd0, cfg.sifs_slots}
		+ {5'd0, cfg.ack_slots});

	// arrival and timer decrement come before the mode step
	assign pend_arr = (packet_arrived && ({24'd0, pend_q} < 32'(QUEUE_LIMIT)))
		? pend_q + 8'd1 : pend_q;
	assign t_dec    = (timer_q != 13'd0) ? timer_q - 13'd1 : timer_q;

	// mode step
	always_comb begin
		mode_n    = mode_q;
		timer_n   = t_dec;
		backoff_n = backoff_q;
		win_n     = win_q;
		pend_n    = pend_arr;
		ack_ok_n  = ack_ok_q;
		succ_n    = succ_q;
		coll_n    = coll_q;
		deliv     = 1'b0;
		fail      = 1'b0;
		change    = CHG_NONE;
		unique case (mode_q)
			MODE_WAIT: begin
				if (pend_arr != 8'd0) begin
					if (busy) begin
						mode_n  = MODE_NAV;
						timer_n = nav_len;
					end else begin
						mode_n  = MODE_DIFS;
						timer_n = {5'd0, cfg.difs_slots};
					end
				end
			end
			MODE_DIFS: begin
				if (busy) begin
					mode_n  = MODE_NAV;
					timer_n = nav_len;
				end else if (t_dec == 13'd0) begin
					mode_n  = MODE_BACKOFF;
					timer_n = {3'd0, backoff_q};
				end
			end
			MODE_NAV: begin
				if (!busy || t_dec == 13'd0) begin
					mode_n  = MODE_DIFS;
					timer_n = {5'd0, cfg.difs_slots};
				end
			end
			MODE_BACKOFF: begin
				// remainder is kept for a resume after NAV
				backoff_n = t_dec[9:0];
				if (t_dec == 13'd0) begin
					mode_n  = MODE_SENDING;
					timer_n = {1'b0, cfg.send_slots};
					change  = CHG_OCCUPY;
				end else if (busy) begin
					mode_n  = MODE_NAV;
					timer_n = nav_len;
				end
			end
			MODE_SENDING: begin
				if (t_dec == 13'd0) begin
					mode_n  = MODE_SIFS;
					timer_n = {5'd0, cfg.sifs_slots};
				end
			end
			MODE_SIFS: begin
				if (t_dec == 13'd0) begin
					mode_n   = MODE_ACK;
					timer_n  = {5'd0, cfg.ack_slots};
					ack_ok_n = 1'b1;
					change   = CHG_RELEASE;
				end
			end
			MODE_ACK: begin
				ack_ok_n = ack_ok_q & ack_valid;
				if (t_dec == 13'd0) begin
					if (ack_ok_n) begin
						deliv = 1'b1;
						if (succ_q != 16'hFFFF)
							succ_n = succ_q + 16'd1;
						win_n = cfg.window_min_log2;
						if (pend_arr != 8'd0)
							pend_n = pend_arr - 8'd1;
					end else begin
						fail = 1'b1;
						if (coll_q != 16'hFFFF)
							coll_n = coll_q + 16'd1;
						if (win_q < cfg.window_max_log2)
							win_n = win_q + 4'd1;
					end
					backoff_n = random_word & win_mask(win_n);
					mode_n    = MODE_WAIT;
				end
			end
			default: mode_n = MODE_WAIT;
		endcase
	end

	// station state, updated once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_WAIT;
			timer_q   <= '0;
			backoff_q <= '0;
			win_q     <= WIN_MIN_RST;
			pend_q    <= '0;
			ack_ok_q  <= 1'b0;
			succ_q    <= '0;
			coll_q    <= '0;
		end else if (accept) begin
			mode_q    <= mode_n;
			timer_q   <= timer_n;
			backoff_q <= backoff_n;
			win_q     <= win_n;
			pend_q    <= pend_n;
			ack_ok_q  <= ack_ok_n;
			succ_q    <= succ_n;
			coll_q    <= coll_n;
		end
	end

	assign res.channel_change  = change;
	assign res.station_mode    = mode_code(mode_n);
	assign res.delivered       = deliv;
	assign res.failed          = fail;
	assign res.queue_count     = pend_n;
	assign res.success_total   = succ_n;
	assign res.collision_total = coll_n;

endmodule

FILE: hdl/csf_outbuf.sv
module csf_outbuf
	import csf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t din,
	output logic full,
	output logic valid,
	input  logic stall,
	output res_t dout
);

	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic take;

	assign take  = out_valid_q & ~stall;
	assign full  = skid_valid_q;
	assign valid = out_valid_q;
	assign dout  = out_q;

	// occupancy of output and skid stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take)
				skid_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			if (out_valid_q && !take)
				skid_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take)
				out_q <= skid_q;
		end else if (load) begin
			if (!out_valid_q || take)
				out_q <= din;
			else
				skid_q <= din;
		end
	end

endmodule

FILE: hdl/csma_ca_sender_fsm.sv
// Slot-tick CSMA/CA sender with binary exponential backoff. Each beat on the
// src channel is one slot (arrival flag, sensed channel level, ACK validity,
// random word) and yields exactly one beat on the res channel carrying the
// channel change, the mode after the slot, the delivered/failed pulses, the
// queue count and the two saturating totals. The station state is updated at
// the accepting edge and the result is registered there, so a new slot is
// taken every cycle while src_stall is low; a two-entry output stage
// (result register plus skid) lets src run on while res is stalled, and
// src_stall rises only when both entries are full. Timing registers are
// written over the APB port at byte address 4*index and apply from the next
// slot that uses them; write them only while the block is idle.
module csma_ca_sender_fsm
	import csf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              src_valid,
	output logic              src_stall,
	input  logic              packet_arrived,
	input  logic [1:0]        channel_level,
	input  logic              ack_valid,
	input  logic [9:0]        random_word,
	output logic              res_valid,
	input  logic              res_stall,
	output logic signed [1:0] channel_change,
	output logic [2:0]        station_mode,
	output logic              delivered,
	output logic              failed,
	output logic [7:0]        queue_count,
	output logic [15:0]       success_total,
	output logic [15:0]       collision_total
);

	cfg_t cfg;
	res_t res_d, res_q;
	logic full;
	logic accept;

	assign src_stall = full;
	assign accept    = src_valid & ~full;

	csf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	csf_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.packet_arrived (packet_arrived),
		.channel_level  (channel_level),
		.ack_valid      (ack_valid),
		.random_word    (random_word),
		.cfg            (cfg),
		.res            (res_d)
	);

	csf_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.din    (res_d),
		.full   (full),
		.valid  (res_valid),
		.stall  (res_stall),
		.dout   (res_q)
	);

	assign channel_change  = res_q.channel_change;
	assign station_mode    = res_q.station_mode;
	assign delivered       = res_q.delivered;
	assign failed          = res_q.failed;
	assign queue_count     = res_q.queue_count;
	assign success_total   = res_q.success_total;
	assign collision_total = res_q.collision_total;

endmodule

FILE: tb/sv/csma_ca_sender_fsm_test.sv
import csf_pkg::*;

// Tracks the station state slot by slot and holds the outcomes still owed by the block
class station_tracker;
	cfg_t       cfg;
	logic [2:0] mode;
	logic [12:0] timer;
	logic [9:0] remainder;
	logic [3:0] win_exp;
	logic [7:0] backlog;
	logic       ack_clean;
	logic [15:0] wins;
	logic [15:0] losses;
	res_t       outcomes_due[$];
	int         faults;

	function new();
		cfg.difs_slots      = DIFS_RST;
		cfg.send_slots      = SEND_RST;
		cfg.sifs_slots      = SIFS_RST;
		cfg.ack_slots       = ACK_RST;
		cfg.window_min_log2 = WIN_MIN_RST;
		cfg.window_max_log2 = WIN_MAX_RST;
		mode      = CODE_WAIT;
		timer     = '0;
		remainder = '0;
		win_exp   = WIN_MIN_RST;
		backlog   = '0;
		ack_clean = 1'b0;
		wins      = '0;
		losses    = '0;
		faults    = 0;
	endfunction

	function void set_reg(input reg_idx_t idx, input logic [31:0] value);
		case (idx)
			REG_DIFS:    cfg.difs_slots      = value[7:0];
			REG_SEND:    cfg.send_slots      = value[11:0];
			REG_SIFS:    cfg.sifs_slots      = value[7:0];
			REG_ACK:     cfg.ack_slots       = value[7:0];
			REG_WIN_MIN: cfg.window_min_log2 = value[3:0];
			REG_WIN_MAX: cfg.window_max_log2 = value[3:0];
			default: ;
		endcase
	endfunction

	function void go_nav();
		mode  = CODE_NAV;
		timer = 13'(cfg.send_slots) + 13'(cfg.sifs_slots) + 13'(cfg.ack_slots);
	endfunction

	function void go_difs();
		mode  = CODE_DIFS;
		timer = 13'(cfg.difs_slots);
	endfunction

	// one accepted slot: advance the station and queue the outcome it owes
	function void take_slot(input logic arrived, input logic [1:0] chan,
			input logic ackv, input logic [9:0] rnd);
		res_t        r;
		logic [3:0]  lg;
		logic [10:0] mask;
		r = '0;
		r.channel_change = CHG_NONE;

		if (arrived && backlog < QUEUE_LIMIT)
			backlog++;
		if (timer != 0)
			timer--;

		case (mode)
			CODE_WAIT: begin
				if (backlog != 0) begin
					if (chan != 0)
						go_nav();
					else
						go_difs();
				end
			end
			CODE_DIFS: begin
				if (chan != 0) begin
					go_nav();
				end else if (timer == 0) begin
					mode  = CODE_BACKOFF;
					timer = 13'(remainder);
				end
			end
			CODE_NAV: begin
				if (chan == 0 || timer == 0)
					go_difs();
			end
			CODE_BACKOFF: begin
				// freeze what is left, so a NAV detour resumes from here
				remainder = timer[9:0];
				if (timer == 0) begin
					mode  = CODE_SENDING;
					timer = 13'(cfg.send_slots);
					r.channel_change = CHG_OCCUPY;
				end else if (chan != 0) begin
					go_nav();
				end
			end
			CODE_SENDING: begin
				if (timer == 0) begin
					mode  = CODE_SIFS;
					timer = 13'(cfg.sifs_slots);
				end
			end
			CODE_SIFS: begin
				if (timer == 0) begin
					mode      = CODE_ACK;
					timer     = 13'(cfg.ack_slots);
					ack_clean = 1'b1;
					r.channel_change = CHG_RELEASE;
				end
			end
			CODE_ACK: begin
				if (!ackv)
					ack_clean = 1'b0;
				if (timer == 0) begin
					if (ack_clean) begin
						r.delivered = 1'b1;
						if (wins != 16'hFFFF)
							wins++;
						win_exp = cfg.window_min_log2;
						if (backlog != 0)
							backlog--;
					end else begin
						r.failed = 1'b1;
						if (losses != 16'hFFFF)
							losses++;
						if (win_exp < cfg.window_max_log2)
							win_exp = win_exp + 4'd1;
					end
					// draw the next backoff from the window, exponent capped at ten
					lg        = (win_exp > 4'd10) ? 4'd10 : win_exp;
					mask      = (11'd1 << lg) - 11'd1;
					remainder = rnd & mask[9:0];
					mode      = CODE_WAIT;
				end
			end
			default: mode = CODE_WAIT;
		endcase

		r.station_mode    = mode;
		r.queue_count     = backlog;
		r.success_total   = wins;
		r.collision_total = losses;
		outcomes_due = {outcomes_due, r};
	endfunction

	function void compare(input string field, input int want, input int seen);
		if (want != seen) begin
			$error("%s: expected %0d, got %0d", field, want, seen);
			faults++;
		end
	endfunction

	// one accepted result beat against the oldest outcome owed
	function void match_outcome(input res_t got);
		res_t want;
		if (outcomes_due.size() == 0) begin
			$error("result beat with nothing outstanding");
			faults++;
			return;
		end
		want = outcomes_due.pop_front();
		compare("channel_change", int'(want.channel_change), int'(got.channel_change));
		compare("station_mode", int'(want.station_mode), int'(got.station_mode));
		compare("delivered", int'(want.delivered), int'(got.delivered));
		compare("failed", int'(want.failed), int'(got.failed));
		compare("queue_count", int'(want.queue_count), int'(got.queue_count));
		compare("success_total", int'(want.success_total), int'(got.success_total));
		compare("collision_total", int'(want.collision_total),
			int'(got.collision_total));
	endfunction

	function int owed();
		return outcomes_due.size();
	endfunction
endclass

module csma_ca_sender_fsm_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0]  difs;
		logic [11:0] send;
		logic [7:0]  sifs;
		logic [7:0]  ack;
		logic [3:0]  wmin;
		logic [3:0]  wmax;
		int          beats;
		int          arrive_pct;
		int          busy_pct;
		int          clean_pct;
	} phase_t;

	typedef struct {
		logic       arrived;
		logic [1:0] chan;
		logic       ackv;
		logic [9:0] rnd;
	} slot_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              src_valid = 1'b0;
	logic              src_stall;
	logic              packet_arrived = 1'b0;
	logic [1:0]        channel_level = '0;
	logic              ack_valid = 1'b0;
	logic [9:0]        random_word = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic signed [1:0] channel_change;
	logic [2:0]        station_mode;
	logic              delivered;
	logic              failed;
	logic [7:0]        queue_count;
	logic [15:0]       success_total;
	logic [15:0]       collision_total;

	station_tracker station = new();
	int src_calm = 0;
	int res_calm = 0;

	csma_ca_sender_fsm i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.src_valid       (src_valid),
		.src_stall       (src_stall),
		.packet_arrived  (packet_arrived),
		.channel_level   (channel_level),
		.ack_valid       (ack_valid),
		.random_word     (random_word),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.channel_change  (channel_change),
		.station_mode    (station_mode),
		.delivered       (delivered),
		.failed          (failed),
		.queue_count     (queue_count),
		.success_total   (success_total),
		.collision_total (collision_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// random pause before a beat, with occasional runs of back-to-back beats
	function automatic int pick_pause(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(31) == 0)
			calm = $urandom_range(40, 10);
		return $urandom_range(15);
	endfunction

	// APB write: setup edge, access edge, then drop the select
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		station.set_reg(idx, value);
	endtask

	task automatic program_timing(input phase_t p);
		write_reg(REG_DIFS, 32'(p.difs));
		write_reg(REG_SEND, 32'(p.send));
		write_reg(REG_SIFS, 32'(p.sifs));
		write_reg(REG_ACK, 32'(p.ack));
		write_reg(REG_WIN_MIN, 32'(p.wmin));
		write_reg(REG_WIN_MAX, 32'(p.wmax));
	endtask

	// one slot beat on the source side, noted once the block takes it
	task automatic drive_slot(input slot_t s);
		int gap;
		gap = pick_pause(src_calm);
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid      <= 1'b1;
		packet_arrived <= s.arrived;
		channel_level  <= s.chan;
		ack_valid      <= s.ackv;
		random_word    <= s.rnd;
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
		station.take_slot(s.arrived, s.chan, s.ackv, s.rnd);
	endtask

	// drain: wait for every outcome to come in, then idle before touching registers
	task automatic drain();
		src_valid <= 1'b0;
		while (station.owed() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// result side: random stalls, every beat checked
	initial begin : result_side
		int   hold;
		res_t got;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			hold = pick_pause(res_calm);
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				res_stall <= 1'b0;
			end
			@(posedge clk);
			while (!res_valid)
				@(posedge clk);
			got = {channel_change, station_mode, delivered, failed, queue_count,
				success_total, collision_total};
			station.match_outcome(got);
		end
	end

	initial begin : stimulus
		phase_t warm_up;
		phase_t phases[5];
		slot_t  walk[25];
		slot_t  s;
		int     r;

		// short stages so the walk-through covers a full cycle
		warm_up = '{8'd1, 12'd1, 8'd1, 8'd2, 4'd0, 4'd10, 0, 0, 0, 0};

		// busy arrival into NAV, NAV held to timeout, DIFS broken by a busy slot,
		// zero first backoff, send on a busy slot, good ACK, then a spoilt ACK
		walk = '{
			'{1'b0, 2'd0, 1'b0, 10'd0},    '{1'b1, 2'd3, 1'b1, 10'd1023},
			'{1'b0, 2'd1, 1'b1, 10'd0},    '{1'b0, 2'd2, 1'b0, 10'd0},
			'{1'b0, 2'd3, 1'b1, 10'd0},    '{1'b0, 2'd1, 1'b1, 10'd0},
			'{1'b0, 2'd2, 1'b1, 10'd0},    '{1'b0, 2'd0, 1'b1, 10'd0},
			'{1'b0, 2'd0, 1'b1, 10'd0},    '{1'b0, 2'd3, 1'b1, 10'd0},
			'{1'b0, 2'd0, 1'b1, 10'd0},    '{1'b0, 2'd0, 1'b0, 10'd0},
			'{1'b1, 2'd0, 1'b1, 10'd0},    '{1'b0, 2'd0, 1'b1, 10'd1023},
			'{1'b0, 2'd0, 1'b1, 10'd0},    '{1'b0, 2'd0, 1'b1, 10'd0},
			'{1'b0, 2'd0, 1'b1, 10'd0},    '{1'b0, 2'd0, 1'b1, 10'd0},
			'{1'b0, 2'd0, 1'b1, 10'd0},    '{1'b0, 2'd0, 1'b0, 10'd1023},
			'{1'b0, 2'd0, 1'b1, 10'd1023}, '{1'b1, 2'd0, 1'b1, 10'd0},
			'{1'b0, 2'd0, 1'b1, 10'd0},    '{1'b0, 2'd1, 1'b1, 10'd0},
			'{1'b0, 2'd0, 1'b1, 10'd512}
		};

		// random phases: stage lengths, window bounds and traffic mix per phase
		phases[0] = '{8'd2, 12'd3, 8'd1, 8'd2, 4'd2, 4'd4, 400, 30, 20, 50};
		phases[1] = '{8'd1, 12'd1, 8'd1, 8'd1, 4'd10, 4'd10, 250, 40, 40, 80};
		phases[2] = '{8'd1, 12'd2, 8'd1, 8'd1, 4'd0, 4'd0, 200, 50, 10, 70};
		phases[3] = '{8'd255, 12'd2, 8'd255, 8'd255, 4'd3, 4'd7, 650, 20, 0, 99};
		// long frames and heavy arrivals last, to fill the queue to its limit
		phases[4] = '{8'd1, 12'd4095, 8'd2, 8'd3, 4'd1, 4'd10, 320, 97, 5, 90};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		program_timing(warm_up);
		foreach (walk[i])
			drive_slot(walk[i]);
		drain();

		foreach (phases[p]) begin
			program_timing(phases[p]);
			for (int n = 0; n < phases[p].beats; n++) begin
				s.arrived = ($urandom_range(99) < phases[p].arrive_pct);
				r = $urandom_range(99);
				s.chan = (r < phases[p].busy_pct) ? 2'($urandom_range(3, 1)) : 2'd0;
				s.ackv = ($urandom_range(99) < phases[p].clean_pct);
				s.rnd  = 10'($urandom_range(1023));
				drive_slot(s);
			end
			drain();
		end

		if (station.faults == 0 && station.owed() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end
endmodule
